@@ rtl/ssort_pkg.sv @@
`timescale 1ns / 1ps

package ssort_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic                  last_in;
    } item_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] sorted_value;
        logic                  last_out;
        logic                  overflow;
    } result_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_BEGIN,
        ST_HEAD,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic begin_pass;
        logic take_head;
        logic scan;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic final_pass;
        logic out_free;
    } status_t;

endpackage

@@ rtl/ssort_ctrl.sv @@
`timescale 1ns / 1ps

module ssort_ctrl
    import ssort_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_last,
    input  status_t status,
    output logic    item_stall,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (item_valid && item_last)
                begin
                    state_next = ST_BEGIN;
                end
            end
            ST_BEGIN:
            begin
                state_next = ST_HEAD;
            end
            ST_HEAD:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.final_pass ? ST_LOAD : ST_BEGIN;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        item_stall     = (state_reg != ST_LOAD);
        cmd.accept     = (state_reg == ST_LOAD) && item_valid;
        cmd.begin_pass = (state_reg == ST_BEGIN);
        cmd.take_head  = (state_reg == ST_HEAD);
        cmd.scan       = (state_reg == ST_SCAN);
        cmd.emit       = (state_reg == ST_EMIT) && status.out_free;
    end

endmodule

@@ rtl/ssort_datapath.sv @@
`timescale 1ns / 1ps

module ssort_datapath
    import ssort_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    input  item_t   item_data,
    input  logic    result_stall,
    output status_t status,
    output logic    result_valid,
    output result_t result_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic [IDX_W-1:0]      i_reg;
    logic [IDX_W-1:0]      i_next;
    logic [CNT_W-1:0]      j_reg;
    logic [CNT_W-1:0]      j_next;
    logic                  rd_pend_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [DATA_WIDTH-1:0] best_val_reg;
    logic [DATA_WIDTH-1:0] best_val_next;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [IDX_W-1:0]      best_idx_next;
    logic [DATA_WIDTH-1:0] head_val_reg;
    logic                  out_valid_reg;
    result_t               out_reg;

    logic                  has_room;
    logic                  issue;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  final_pass;
    logic                  out_free;

    assign has_room   = (count_reg < CNT_W'(DEPTH));
    assign issue      = (cmd.take_head || cmd.scan) && (j_reg < count_reg);
    assign rd_en      = cmd.begin_pass || issue;
    assign rd_addr    = cmd.begin_pass ? i_reg : j_reg[IDX_W-1:0];
    assign final_pass = ({1'b0, i_reg} + CNT_W'(1)) == count_reg;
    assign out_free   = !out_valid_reg || !result_stall;

    assign wr_en   = (cmd.accept && has_room) || cmd.emit;
    assign wr_addr = cmd.emit ? best_idx_reg : count_reg[IDX_W-1:0];
    assign wr_data = cmd.emit ? head_val_reg : item_data.value;

    assign status.scan_done  = !rd_pend_reg && !(j_reg < count_reg);
    assign status.final_pass = final_pass;
    assign status.out_free   = out_free;

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        best_val_next = best_val_reg;
        best_idx_next = best_idx_reg;
        if (cmd.accept)
        begin
            if (has_room)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.begin_pass)
        begin
            j_next = {1'b0, i_reg} + CNT_W'(1);
        end
        if (cmd.take_head)
        begin
            best_val_next = rd_data_reg;
            best_idx_next = i_reg;
        end
        if (issue)
        begin
            j_next = j_reg + CNT_W'(1);
        end
        if (cmd.scan && rd_pend_reg && ($signed(rd_data_reg) < $signed(best_val_reg)))
        begin
            best_val_next = rd_data_reg;
            best_idx_next = rd_idx_reg;
        end
        if (cmd.emit)
        begin
            if (final_pass)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                i_next     = '0;
            end
            else
            begin
                i_next = i_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            rd_pend_reg <= issue;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_val_reg <= best_val_next;
        best_idx_reg <= best_idx_next;
        if (issue)
        begin
            rd_idx_reg <= j_reg[IDX_W-1:0];
        end
        if (cmd.take_head)
        begin
            head_val_reg <= rd_data_reg;
        end
        if (cmd.emit)
        begin
            out_reg.sorted_value <= best_val_reg;
            out_reg.last_out     <= final_pass;
            out_reg.overflow     <= ovf_reg;
        end
    end

`ifndef SYNTHESIS
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> result_valid)
        else $error("An emitted item did not appear on the output.");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!$past(out_valid_reg) || out_free || !out_valid_reg))
        else $error("An item was emitted into an occupied output register.");

    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> cmd.scan)
        else $error("A memory read landed outside the scan.");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && final_pass) |=> (count_reg == '0 && !ovf_reg))
        else $error("The set was not cleared after its final item.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !(cmd.begin_pass || cmd.take_head || cmd.scan || cmd.emit))
        else $error("An item was accepted while sorting.");
`endif

endmodule

@@ rtl/selection_sort_engine.sv @@
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// input     item_valid / item_stall    item_data   (value, last_in)
// output    result_valid / result_stall result_data (sorted_value, last_out, overflow)
//
// Items are taken one per cycle while the set loads; the last item starts the sort.
// For a set of n values the sort does one compare per cycle while it scans,
// a rate set by the single read port of the element memory and the one comparator.
// Every pass emits its minimum into an output register; the pass waits while it is full and stalled.
// No input item is taken from the last item of a set until its final result is emitted.
// Reset clears the control state and the count; the memory needs no clearing pass.

module selection_sort_engine
    import ssort_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item_data,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result_data
);

    cmd_t    cmd;
    status_t status;

    ssort_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_last  (item_data.last_in),
        .status     (status),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    ssort_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item_data    (item_data),
        .result_stall (result_stall),
        .status       (status),
        .result_valid (result_valid),
        .result_data  (result_data)
    );

endmodule
